@@ src/md5h_pkg.sv @@
// md5h_pkg: shared types, constants and tables of the md5 hasher
// (state word struct, initial chaining values, sine table, shift and index schedules)
// no dependencies
`default_nettype none

package md5h_pkg;

    // the four 32-bit working or chaining words
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5h_words_t;

    // block buffer stored as sixteen little-endian 32-bit words
    localparam int BUF_WORDS = 16;
    localparam int WORD_BITS = 32;

    // initial chaining values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // per-round rotate amounts, indexed by round and step mod 4
    function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] sel);
        logic [4:0] s;
        unique case ({rnd, sel})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used at a given step
    function automatic logic [3:0] word_idx(input logic [5:0] k);
        logic [3:0] i;
        logic [3:0] idx;
        i = k[3:0];
        unique case (k[5:4])
            2'd0: idx = i;
            2'd1: idx = 4'(4'd1 + 4'd5 * i);
            2'd2: idx = 4'(4'd5 + 4'd3 * i);
            default: idx = 4'(4'd7 * i);
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ src/md5h_ram.sv @@
// md5h_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module md5h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/md5h_step.sv @@
// md5h_step: one md5 compression step on the working words
// depends on md5h_pkg (word struct, sine table, rotate schedule)
`default_nettype none

module md5h_step (
    input  wire md5h_pkg::md5h_words_t cur,
    input  wire logic [5:0]            k,
    input  wire logic [31:0]           w,
    output md5h_pkg::md5h_words_t      nxt
);
    import md5h_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  s;

    // round function
    always_comb
    begin
        unique case (k[5:4])
            2'd0: f = ((cur.c ^ cur.d) & cur.b) ^ cur.d;
            2'd1: f = ((cur.b ^ cur.c) & cur.d) ^ cur.c;
            2'd2: f = cur.b ^ cur.c ^ cur.d;
            default: f = cur.c ^ (cur.b | ~cur.d);
        endcase
    end

    // add, rotate, add and shuffle the words
    assign s        = rot_amt(k[5:4], k[1:0]);
    assign sum      = cur.a + f + w + SINE_TAB[k];
    assign rot_wide = {sum, sum} << s;
    assign nxt.b    = rot_wide[63:32] + cur.b;
    assign nxt.a    = cur.d;
    assign nxt.c    = cur.b;
    assign nxt.d    = cur.c;

endmodule

`default_nettype wire

@@ src/md5_hash_64bit_digest.sv @@
// md5_hash_64bit_digest: streaming md5 hasher, one byte per transfer, 64-bit digest
// depends on md5h_pkg, md5h_ram (block buffer words) and md5h_step (compression step)
// timing: each data byte is written into the block buffer; the byte that fills a block starts
//   compression, one step per cycle against the block buffer ram read port
// finish: the padding bytes are pushed in turn, each full block is compressed, then the
//   digest transfer; no new item is taken until the digest has been taken
// reset: asynchronous, active low; chaining words set to initial values, counts cleared
`default_nettype none

module md5_hash_64bit_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] digest
);
    import md5h_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMP = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam md5h_words_t INIT_WORDS = '{d: INIT_D, c: INIT_C, b: INIT_B, a: INIT_A};

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pad_reg, pad_next;
    logic        fin_reg, fin_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] msg_reg, msg_next;
    logic [23:0] word_reg, word_next;
    logic [6:0]  cnt_reg, cnt_next;
    md5h_words_t chain_reg, chain_next;
    md5h_words_t work_reg, work_next;

    logic        push_en;
    logic [7:0]  push_val;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [5:0]  step_k;
    md5h_words_t step_out;

    // block buffer words
    md5h_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(BUF_WORDS)
    ) u_buf (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // compression step on the word read in the previous cycle
    assign step_k = 6'(cnt_reg - 7'd1);

    md5h_step u_step (
        .cur(work_reg),
        .k(step_k),
        .w(rd_data),
        .nxt(step_out)
    );

    assign rd_addr = word_idx(cnt_reg[5:0]);

    // message length in bits, little-endian byte select
    assign bit_len  = {msg_reg[60:0], 3'b000};
    assign len_byte = bit_len[8 * fill_reg[2:0] +: 8];

    // handshake outputs
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign digest    = {chain_reg.b, chain_reg.a};

    // sequencer: byte source selection and state updates
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        msg_next   = msg_reg;
        cnt_next   = cnt_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        push_en    = 1'b0;
        push_val   = data_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        state_next = ST_PAD;
                        phase_next = PH_MARK;
                        pad_next   = 1'b1;
                    end
                    else
                    begin
                        push_en  = 1'b1;
                        msg_next = msg_reg + 64'd1;
                    end
                end
            end
            ST_PAD:
            begin
                unique case (phase_reg)
                    PH_MARK:
                    begin
                        push_en    = 1'b1;
                        push_val   = PAD_BYTE;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg == 6'd56)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            push_en  = 1'b1;
                            push_val = 8'h00;
                        end
                    end
                    default:
                    begin
                        push_en  = 1'b1;
                        push_val = len_byte;
                        if (fill_reg == 6'd63)
                        begin
                            fin_next = 1'b1;
                        end
                    end
                endcase
            end
            ST_COMP:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0)
                begin
                    work_next = step_out;
                end
                if (cnt_reg == 7'd64)
                begin
                    chain_next.a = chain_reg.a + step_out.a;
                    chain_next.b = chain_reg.b + step_out.b;
                    chain_next.c = chain_reg.c + step_out.c;
                    chain_next.d = chain_reg.d + step_out.d;
                    priority if (fin_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (pad_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                    chain_next = INIT_WORDS;
                    msg_next   = 64'd0;
                    fin_next   = 1'b0;
                    pad_next   = 1'b0;
                end
            end
        endcase

        // a full block starts compression
        if (push_en && fill_reg == 6'd63)
        begin
            state_next = ST_COMP;
            cnt_next   = 7'd0;
            work_next  = chain_reg;
        end
    end

    // byte gathering into buffer words
    always_comb
    begin
        fill_next = fill_reg;
        word_next = word_reg;
        wr_en     = 1'b0;
        wr_addr   = fill_reg[5:2];
        wr_data   = {push_val, word_reg};
        if (push_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'd3)
            begin
                wr_en = 1'b1;
            end
            else
            begin
                word_next = {push_val, word_reg[23:8]};
            end
        end
        else if (state_reg == ST_OUT && !out_stall)
        begin
            fill_next = 6'd0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MARK;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            fill_reg  <= 6'd0;
            msg_reg   <= 64'd0;
            cnt_reg   <= 7'd0;
            chain_reg <= INIT_WORDS;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            fill_reg  <= fill_next;
            msg_reg   <= msg_next;
            cnt_reg   <= cnt_next;
            chain_reg <= chain_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        work_reg <= work_next;
    end

endmodule

`default_nettype wire
